// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_core; no dependencies.
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int TOTAL_W = 5;
  localparam int STAT_W  = 2;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 72;
  localparam int S_USER_W = 1;
  localparam int M_USER_W = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply the latched request and load the result register
  } spq_cmd_t;

  typedef struct packed {
    logic out_valid;  // result register holds an untaken result
  } spq_stat_t;

endpackage

// ===== sv/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: take a request, then apply it.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;

  // the result register frees up either when empty or when taken this cycle
  assign slot_free = !stat.out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/spq_datapath.sv =====
// Slot array with parallel compare-and-shift, request latch and result register.
// Depends on spq_pkg; driven by commands from spq_ctrl.
module spq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::spq_cmd_t                   cmd,
  output spq_pkg::spq_stat_t                  stat,
  input  logic                                in_kind,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_prio,
  input  logic                                m_tready,
  output logic signed [spq_pkg::VALUE_W-1:0]  removed_value,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  output logic        [spq_pkg::TOTAL_W-1:0]  entry_total,
  output logic        [spq_pkg::STAT_W-1:0]   status
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] slot_val [DEPTH];
  logic signed [PRIO_W-1:0]  slot_pri [DEPTH];
  logic signed [VALUE_W-1:0] slot_val_next [DEPTH];
  logic signed [PRIO_W-1:0]  slot_pri_next [DEPTH];
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  logic                      req_kind;
  logic signed [VALUE_W-1:0] req_value;
  logic signed [PRIO_W-1:0]  req_prio;

  logic                      out_valid;
  logic [DEPTH-1:0]          ins;
  logic                      head_tie;
  logic                      full;
  logic                      empty;
  logic                      do_enq;
  logic                      do_deq;
  logic [STAT_W-1:0]         status_next;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_enq   = (req_kind == KIND_ENQ) && !full;
  assign do_deq   = (req_kind == KIND_DEQ) && !empty;
  assign head_tie = !empty && (req_prio >= slot_pri[0]);

  // ins marks slots that take a shifted entry or the new one; it runs from
  // the insertion point up to the first free slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) < count) begin
        ins[i] = head_tie || (slot_pri[i] < req_prio);
      end else begin
        ins[i] = (CNT_W'(i) == count);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_val_next[i] = slot_val[i];
      slot_pri_next[i] = slot_pri[i];
      if (do_enq && ins[i]) begin
        if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
          slot_val_next[i] = slot_val[(i > 0) ? i - 1 : 0];
          slot_pri_next[i] = slot_pri[(i > 0) ? i - 1 : 0];
        end else begin
          slot_val_next[i] = req_value;
          slot_pri_next[i] = req_prio;
        end
      end else if (do_deq && i < DEPTH - 1) begin
        slot_val_next[i] = slot_val[(i < DEPTH - 1) ? i + 1 : i];
        slot_pri_next[i] = slot_pri[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = STAT_DONE;
    if (req_kind == KIND_ENQ) begin
      if (full) begin
        status_next = STAT_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = STAT_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= in_kind;
      req_value <= in_value;
      req_prio  <= in_prio;
    end
  end

  // slot store holds no reset; only slots below count are ever used
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_val[i] <= slot_val_next[i];
        slot_pri[i] <= slot_pri_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.execute) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      removed_value <= do_deq ? slot_val[0] : '0;
      head_value    <= (count_next != '0) ? slot_val_next[0] : '0;
      entry_total   <= TOTAL_W'(count_next);
      status        <= status_next;
    end
  end

  assign stat.out_valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_exec_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("result register not loaded after execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!out_valid || m_tready))
    else $error("execute would overwrite an untaken result");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && req_kind == KIND_ENQ && full) |=> (count == $past(count)))
    else $error("dropped enqueue changed the count");

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Sorted priority queue of spq_pkg::DEPTH entries: top level joining
// spq_ctrl and spq_datapath. Depends on spq_pkg.
//
// Each request (enqueue or dequeue) is first latched and then applied across
// all slots at once with a parallel compare-and-shift; a new request is
// accepted only once the previous one has been applied to the slots.
// The one result register lets the next request enter while a result waits;
// execution stalls only if that result is still not taken. Entries stay sorted
// by priority, highest at slot 0; a new entry whose priority equals or beats the
// head goes in front of it, otherwise it goes behind all equal priorities.
// Dequeue on empty reports status 1; enqueue when full is dropped with status 2.
module sorted_priority_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // item_value[31:0], item_priority[47:32]
  input  logic [spq_pkg::S_DATA_W-1:0]      s_tdata,
  // kind[0]
  input  logic [spq_pkg::S_USER_W-1:0]      s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // removed_value[31:0], head_value[63:32], entry_total[68:64], zero[71:69]
  output logic [spq_pkg::M_DATA_W-1:0]      m_tdata,
  // status[1:0]
  output logic [spq_pkg::M_USER_W-1:0]      m_tuser
);
  import spq_pkg::*;

  spq_cmd_t                  cmd;
  spq_stat_t                 stat;
  logic signed [VALUE_W-1:0] removed_value;
  logic signed [VALUE_W-1:0] head_value;
  logic [TOTAL_W-1:0]        entry_total;
  logic [STAT_W-1:0]         status;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (s_tuser[0]),
    .in_value      (s_tdata[VALUE_W-1:0]),
    .in_prio       (s_tdata[VALUE_W+PRIO_W-1:VALUE_W]),
    .m_tready      (m_tready),
    .removed_value (removed_value),
    .head_value    (head_value),
    .entry_total   (entry_total),
    .status        (status)
  );

  assign m_tvalid = stat.out_valid;
  assign m_tdata  = {(M_DATA_W - 2*VALUE_W - TOTAL_W)'(0), entry_total, head_value,
                     removed_value};
  assign m_tuser  = status;

endmodule

// ===== test/sorted_priority_queue_core_tb.sv =====
// Self-checking testbench for sorted_priority_queue_core: ordered insert, head removal,
// empty and full status, with random stalls on both stream sides.
// Depends on spq_pkg and the core RTL only.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  typedef struct packed {
    logic              wait_drain;  // hold this request until every result is back
    logic              kind;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] removed;
    logic [VALUE_W-1:0] head;
    logic [TOTAL_W-1:0] total;
    logic [STAT_W-1:0]  status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  sorted_priority_queue_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents
  logic [VALUE_W-1:0]        shadow_value [DEPTH];
  logic signed [PRIO_W-1:0]  shadow_prio  [DEPTH];
  int                        shadow_count = 0;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t cur_req;
  result_t  want;

  int  mismatches = 0;
  int  results_seen = 0;
  int  enq_total = 0;
  int  deq_total = 0;
  int  full_drops = 0;
  int  empty_deqs = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  logic tx_idle_en = 1'b0;
  logic rx_idle_en = 1'b0;
  logic hold_go = 1'b0;
  logic hold_rx = 1'b0;

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic result_t apply_request(request_t r);
    result_t res;
    int pos;
    int i;
    logic found;
    logic signed [PRIO_W-1:0] p;
    res = '0;
    res.status = STAT_DONE;
    p = $signed(r.prio);
    if (r.kind == KIND_ENQ) begin
      enq_total++;
      if (shadow_count >= DEPTH) begin
        res.status = STAT_FULL;
        full_drops++;
      end else begin
        pos = shadow_count;
        if (shadow_count == 0 || p >= shadow_prio[0]) begin
          pos = 0;
        end else begin
          // walk to the first entry of strictly lower priority
          found = 1'b0;
          i = 1;
          while (i < shadow_count && !found) begin
            if (shadow_prio[i] < p) begin
              pos = i;
              found = 1'b1;
            end
            i++;
          end
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = r.value;
        shadow_prio[pos]  = p;
        shadow_count++;
      end
    end else begin
      deq_total++;
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
        empty_deqs++;
      end else begin
        res.removed = shadow_value[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_value[i-1] = shadow_value[i];
          shadow_prio[i-1]  = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    res.head  = (shadow_count != 0) ? shadow_value[0] : '0;
    res.total = shadow_count[TOTAL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] exp_val);
    mismatches++;
    $display("[%0t] mismatch on %s at result %0d: got %h, want %h",
             $time, field, results_seen, got, exp_val);
  endtask

  task automatic add_request(input logic kind, input logic [VALUE_W-1:0] value,
                             input logic [PRIO_W-1:0] prio, input logic wait_drain);
    request_t r;
    r.wait_drain = wait_drain;
    r.kind       = kind;
    r.value      = value;
    r.prio       = prio;
    pending_requests.push_back(r);
  endtask

  function automatic logic [PRIO_W-1:0] pick_priority();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return PRIO_W'($urandom_range(0, 8)) - PRIO_W'(4);  // dense: many ties
      5:             return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default:       return r[PRIO_W-1:0];
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Runs biased toward enqueue or dequeue push the queue to full and back to empty.
  task automatic add_random(input int count, input int drain_every);
    int left;
    int run_left;
    int enq_pct;
    int n;
    logic kind;
    left = count;
    run_left = 0;
    enq_pct = 50;
    n = 0;
    while (left > 0) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       enq_pct = 80;
          1:       enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
      add_request(kind, pick_value(), pick_priority(),
                  drain_every != 0 && (n % drain_every) == 0);
      n++;
      run_left--;
      left--;
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_request(cur_req));
        if (tx_idle_en && $urandom_range(0, 4) == 0)
          tx_gap = $urandom_range(1, 13);
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until it is taken
      end else if (tx_gap != 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_drain && expected_results.size() != 0)) begin
        cur_req = pending_requests.pop_front();
        s_tdata  <= {cur_req.prio, cur_req.value};
        s_tuser  <= cur_req.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.removed)
            report_mismatch("removed_value", m_tdata[31:0], want.removed);
          if (m_tdata[63:32] !== want.head)
            report_mismatch("head_value", m_tdata[63:32], want.head);
          if (m_tdata[68:64] !== want.total)
            report_mismatch("entry_total", 32'(m_tdata[68:64]), 32'(want.total));
          if (m_tdata[71:69] !== 3'b000)
            report_mismatch("tdata pad", 32'(m_tdata[71:69]), '0);
          if (m_tuser !== want.status)
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
        end
      end
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the core's result register fills and it backs up its input
  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;

    // Directed: empty dequeue, ties at head and mid-list, tail inserts, fill, full drops
    add_request(KIND_DEQ, 32'h1234_5678, 16'h0000, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0011, 16'h0000, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0022, 16'h0000, 1'b0);
    add_request(KIND_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    add_request(KIND_ENQ, 32'h8000_0000, 16'h8000, 1'b0);
    add_request(KIND_ENQ, 32'hFFFF_FFFF, 16'h8000, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0033, 16'd100, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0044, 16'd100, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0055, 16'hFFFF, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0066, 16'h7FFF, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0077, 16'd5, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0088, 16'hFFFB, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0099, 16'd100, 1'b0);
    add_request(KIND_ENQ, 32'h0000_00AA, 16'h0000, 1'b0);
    add_request(KIND_ENQ, 32'h0000_00BB, 16'd1, 1'b0);
    add_request(KIND_ENQ, 32'h0000_00CC, 16'h8001, 1'b0);
    add_request(KIND_ENQ, 32'h0000_00DD, 16'd200, 1'b0);
    add_request(KIND_ENQ, 32'hDEAD_BEEF, 16'h7FFF, 1'b0);
    add_request(KIND_ENQ, 32'h0000_0000, 16'h8000, 1'b0);
    repeat (6) add_request(KIND_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);

    add_random(800, 0);
    while (pending_requests.size() != 0) @(posedge clk);

    // Sender keeps offering while the receiver holds off
    tx_idle_en <= 1'b0;
    add_random(60, 0);
    hold_go <= 1'b1;
    while (pending_requests.size() != 0) @(posedge clk);

    // Pause for a full drain now and then
    tx_idle_en <= 1'b1;
    add_random(800, 200);
    while (pending_requests.size() != 0) @(posedge clk);

    // Closing stretch at full rate
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    add_random(180, 0);

    while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d enqueues (%0d full drops), %0d dequeues (%0d empty).",
             enq_total + deq_total, enq_total, full_drops, deq_total, empty_deqs);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
